[sv/btds_pkg.sv]
// Shared types and codes for the byte translate, delete and squeeze filter.
package btds_pkg;

  // One character table entry: mapped byte, delete mark and squeeze mark.
  typedef struct packed {
    logic       sqz;
    logic       del;
    logic [7:0] map;
  } btds_entry_t;

  // Item function codes.
  typedef enum logic {
    FUNC_DATA  = 1'b0,
    FUNC_WRITE = 1'b1
  } btds_func_e;

  // Configuration register indexes, taken from paddr[2].
  typedef enum logic {
    REG_DEL_MODE     = 1'b0,
    REG_SQUEEZE_MODE = 1'b1
  } btds_reg_e;

  localparam int unsigned TableDepth = 256;

endpackage

[sv/byte_translate_delete_squeeze.sv]
// Top level of the byte translate, delete and squeeze filter.
//
// Input channel (in_valid_i / in_stall_o) carries either a data byte to filter
// (func_i = 0) or a character table write (func_i = 1) that loads the entry at
// data_byte_i with map_byte_i, delete_flag_i and squeeze_flag_i. A table write
// gives no result. Output channel (out_valid_o / out_stall_i) carries one
// out_byte_o for every data byte that is neither deleted nor squeezed.
// One item is taken in every cycle while in_stall_o is low. A surviving data
// byte passes registered stages in order: stage 1 holds the table entry at the
// data byte, stage 2 the entry at the translated byte (the data byte itself in
// delete mode), and the output register is loaded once the squeeze compare
// against the last emitted byte is done. Bubbles left by deleted, squeezed or
// table-write items close up when the receiver stalls, so in_stall_o rises
// only once all three stages hold bytes and the output is stalled. The delete
// and squeeze modes are written over the APB port at addresses 0 and 4; the
// user must do so only while the filter is idle; the block does not enforce it.
// Reset is asynchronous: it empties the pipeline, clears both modes and the
// squeeze history, and marks every table entry as reading the identity map
// with both flags clear, at once, with no clearing pass.
module byte_translate_delete_squeeze (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  map_byte_i,
  input  logic        delete_flag_i,
  input  logic        squeeze_flag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import btds_pkg::*;

  // Configuration
  logic del_mode_q;
  logic squeeze_mode_q;
  logic cfg_we;

  // Table
  btds_entry_t            tbl_mem [TableDepth];
  logic [TableDepth-1:0]  tbl_vld_q;
  btds_entry_t            rd_a_q;
  btds_entry_t            rd_b_q;
  logic                   val_a_q;
  logic                   val_b_q;
  logic                   tbl_we;
  logic                   rd_a_en;
  logic                   rd_b_en;

  // Pipeline
  logic        in_acc;
  logic        s1_en;
  logic        s2_en;
  logic        out_en;
  logic        s1_vld_q;
  logic [7:0]  s1_byte_q;
  btds_entry_t s1_entry;
  logic        s1_keep;
  logic [7:0]  s1_res;
  logic        s2_vld_q;
  logic [7:0]  s2_res_q;
  logic        s2_sqz;
  logic        s2_drop;
  logic        s2_emit;
  logic        out_vld_q;
  logic [7:0]  out_byte_q;
  logic [7:0]  last_byte_q;
  logic        last_sqz_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      del_mode_q     <= 1'b0;
      squeeze_mode_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (btds_reg_e'(paddr[2]))
        REG_DEL_MODE:     del_mode_q     <= pwdata[0];
        REG_SQUEEZE_MODE: squeeze_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (btds_reg_e'(paddr[2]))
      REG_DEL_MODE:     prdata[0] = del_mode_q;
      REG_SQUEEZE_MODE: prdata[0] = squeeze_mode_q;
      default:          prdata    = '0;
    endcase
  end

  // Handshake: each stage moves when the one after it is empty or moving.
  assign out_en     = !out_vld_q || !out_stall_i;
  assign s2_en      = !s2_vld_q || out_en;
  assign s1_en      = !s1_vld_q || s2_en;
  assign in_stall_o = !s1_en;
  assign in_acc     = in_valid_i && s1_en;

  assign tbl_we  = in_acc && (btds_func_e'(func_i) == FUNC_WRITE);
  assign rd_a_en = in_acc && (btds_func_e'(func_i) == FUNC_DATA);
  assign rd_b_en = s1_vld_q && s2_en;

  // Reads return the old contents when a write lands on the same edge, so the
  // second lookup of a byte never sees a table write that followed it.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[data_byte_i] <= '{sqz: squeeze_flag_i, del: delete_flag_i, map: map_byte_i};
    end
    if (rd_a_en) begin
      rd_a_q <= tbl_mem[data_byte_i];
    end
    if (rd_b_en) begin
      rd_b_q <= tbl_mem[s1_res];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
      val_a_q   <= 1'b0;
      val_b_q   <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_q[data_byte_i] <= 1'b1;
      end
      if (rd_a_en) begin
        val_a_q <= tbl_vld_q[data_byte_i];
      end
      if (rd_b_en) begin
        val_b_q <= tbl_vld_q[s1_res];
      end
    end
  end

  // Stage 1: delete check in delete mode, translation otherwise.
  always_comb begin
    if (val_a_q) begin
      s1_entry = rd_a_q;
    end else begin
      s1_entry = '{sqz: 1'b0, del: 1'b0, map: s1_byte_q};
    end
    s1_keep = !(del_mode_q && s1_entry.del);
    s1_res  = del_mode_q ? s1_byte_q : s1_entry.map;
  end

  // Stage 2: squeeze against the last emitted byte.
  assign s2_sqz  = squeeze_mode_q && val_b_q && rd_b_q.sqz;
  assign s2_drop = s2_sqz && last_sqz_q && (s2_res_q == last_byte_q);
  assign s2_emit = s2_vld_q && !s2_drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      last_byte_q <= '0;
      last_sqz_q  <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_q <= rd_a_en;
      end
      if (s2_en) begin
        s2_vld_q <= s1_vld_q && s1_keep;
      end
      if (out_en) begin
        out_vld_q <= s2_emit;
        if (s2_emit) begin
          last_byte_q <= s2_res_q;
          last_sqz_q  <= s2_sqz;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_a_en) begin
      s1_byte_q <= data_byte_i;
    end
    if (s2_en) begin
      s2_res_q <= s1_res;
    end
    if (out_en && s2_emit) begin
      out_byte_q <= s2_res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;

endmodule

[sv/btds_checker.sv]
// Port-level checks for the byte translate, delete and squeeze filter.
module btds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import btds_pkg::*;

  // A stalled result stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed or vanished");

  // The input side is held back only by a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // Nothing leaves the pipeline in the first cycles after reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("result appeared too soon after reset");

  // A delete mode write reads back on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == REG_DEL_MODE))
    ##1 (psel && !pwrite && (paddr[2] == REG_DEL_MODE))
    |-> prdata[0] == $past(pwdata[0]))
    else $error("delete mode readback mismatch");

endmodule

bind byte_translate_delete_squeeze btds_checker u_btds_checker (.*);
